// File: hdl/thfs_pkg.sv
// ----------------------------------------------------------------------------
// thfs_pkg
// Shared types and constants for the temporal history frame sequencer:
// request codes, reset-mask bit positions, the result record and the
// Halton(2,3) jitter tables.
// ----------------------------------------------------------------------------
package thfs_pkg;

    // Request codes carried on req_type
    typedef enum logic [1:0] {
        REQ_BEGIN  = 2'd0,
        REQ_COMMIT = 2'd1,
        REQ_CANCEL = 2'd2
    } req_code_t;

    // Reset mask bit positions
    localparam int RST_DISABLED  = 0;
    localparam int RST_ACTIVATED = 1;
    localparam int RST_EXTENT    = 2;
    localparam int RST_VIEW      = 3;
    localparam int RST_TOPOLOGY  = 4;
    localparam int RST_GAP       = 5;
    localparam int RST_CUT       = 6;

    localparam int MASK_W  = 7;
    localparam int PHASE_W = 3;
    localparam int JIT_W   = 16;
    localparam int EXT_W   = 15;
    localparam int ID_W    = 32;

    // One result item
    typedef struct packed {
        logic                     accepted;
        logic                     plan_enabled;
        logic [MASK_W-1:0]        reset_mask;
        logic [ID_W-1:0]          generation;
        logic                     history_valid;
        logic                     history_read_index;
        logic                     history_write_index;
        logic [PHASE_W-1:0]       jitter_phase;
        logic signed [JIT_W-1:0]  jitter_x;
        logic signed [JIT_W-1:0]  jitter_y;
        logic signed [JIT_W-1:0]  prev_jitter_x;
        logic signed [JIT_W-1:0]  prev_jitter_y;
    } result_t;

    // Base-2 radical inverse of (phase + 1), Q0.16 rounded, less one half
    function automatic logic signed [JIT_W-1:0] halton2_q16(input logic [PHASE_W-1:0] ph);
        logic signed [JIT_W-1:0] v;
        begin
            case (ph)
                3'd0:    v = 16'sd0;
                3'd1:    v = -16'sd16384;
                3'd2:    v = 16'sd16384;
                3'd3:    v = -16'sd24576;
                3'd4:    v = 16'sd8192;
                3'd5:    v = -16'sd8192;
                3'd6:    v = 16'sd24576;
                default: v = -16'sd28672;
            endcase
            return v;
        end
    endfunction

    // Base-3 radical inverse of (phase + 1), Q0.16 rounded, less one half
    function automatic logic signed [JIT_W-1:0] halton3_q16(input logic [PHASE_W-1:0] ph);
        logic signed [JIT_W-1:0] v;
        begin
            case (ph)
                3'd0:    v = -16'sd10923;
                3'd1:    v = 16'sd10923;
                3'd2:    v = -16'sd25486;
                3'd3:    v = -16'sd3641;
                3'd4:    v = 16'sd18204;
                3'd5:    v = -16'sd18204;
                3'd6:    v = 16'sd3641;
                default: v = 16'sd25486;
            endcase
            return v;
        end
    endfunction

endpackage

// File: hdl/temporal_history_frame_sequencer_unit.sv
// ----------------------------------------------------------------------------
// temporal_history_frame_sequencer_unit
// Temporal AA history controller: plans history resets, ping-pong buffers
// and Halton(2,3) jitter per frame, with begin / commit / cancel requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready) carries one request item: begin, commit
//   or cancel, with frame id, extent, view and topology epoch. Output
//   channel (m_valid/m_ready) returns exactly one result item per request.
//   A begin plans a frame and holds it pending; a commit naming the same
//   frame makes it the committed state, a cancel drops it.
//   Path: a request is taken into the input register, then its result into
//   the result register, where the receiver takes it. Throughput: one item
//   per cycle while the receiver does not stall;
//   the plan is decided in one pass of logic between the two registers and
//   the frame state updates as the item enters the result register.
//   Reset (aresetn low, synchronous): no pending plan, history invalid,
//   generation and last committed frame zero, both channels empty.
//   Receiver stall: the result register holds its item; the input register
//   still takes one more item, then s_ready drops until m_ready returns.
//   UV jitter (pixel jitter over extent) is left to software.
// ----------------------------------------------------------------------------
module temporal_history_frame_sequencer_unit
    import thfs_pkg::*;
#(
    parameter int JITTER_PHASES = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_req_type,
    input  logic [ID_W-1:0]          s_frame_id,
    input  logic                     s_enabled,
    input  logic                     s_camera_cut,
    input  logic [EXT_W-1:0]         s_width,
    input  logic [EXT_W-1:0]         s_height,
    input  logic [ID_W-1:0]          s_view_id,
    input  logic [ID_W-1:0]          s_topology_epoch,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_accepted,
    output logic                     m_plan_enabled,
    output logic [MASK_W-1:0]        m_reset_mask,
    output logic [ID_W-1:0]          m_generation,
    output logic                     m_history_valid,
    output logic                     m_history_read_index,
    output logic                     m_history_write_index,
    output logic [PHASE_W-1:0]       m_jitter_phase,
    output logic signed [JIT_W-1:0]  m_jitter_x,
    output logic signed [JIT_W-1:0]  m_jitter_y,
    output logic signed [JIT_W-1:0]  m_prev_jitter_x,
    output logic signed [JIT_W-1:0]  m_prev_jitter_y
);

    // Phase wrap point, compared on a 9-bit scale (up to 8 phases with a 3-bit phase)
    localparam logic [8:0] PH_WRAP = 9'(JITTER_PHASES);

    // Input register
    logic                 in_valid_reg;
    logic [1:0]           in_req_reg;
    logic [ID_W-1:0]      in_frame_reg;
    logic                 in_en_reg;
    logic                 in_cut_reg;
    logic [EXT_W-1:0]     in_w_reg;
    logic [EXT_W-1:0]     in_h_reg;
    logic [ID_W-1:0]      in_view_reg;
    logic [ID_W-1:0]      in_epoch_reg;

    // Result register
    logic                 out_valid_reg;
    result_t              out_reg;

    // Committed state
    logic                     active_reg;
    logic                     history_ok_reg;
    logic                     last_wbuf_reg;
    logic [PHASE_W-1:0]       next_phase_reg;
    logic signed [JIT_W-1:0]  saved_jx_reg;
    logic signed [JIT_W-1:0]  saved_jy_reg;
    logic [ID_W-1:0]          gen_count_reg;
    logic [ID_W-1:0]          last_commit_reg;
    logic [EXT_W-1:0]         com_w_reg;
    logic [EXT_W-1:0]         com_h_reg;
    logic [ID_W-1:0]          com_view_reg;
    logic [ID_W-1:0]          com_epoch_reg;

    // Pending plan
    logic                     pend_reg;
    logic [ID_W-1:0]          pend_frame_reg;
    logic                     pend_en_reg;
    logic [ID_W-1:0]          pend_gen_reg;
    logic                     pend_wbuf_reg;
    logic [PHASE_W-1:0]       pend_phase_reg;
    logic signed [JIT_W-1:0]  pend_jx_reg;
    logic signed [JIT_W-1:0]  pend_jy_reg;
    logic [EXT_W-1:0]         pend_w_reg;
    logic [EXT_W-1:0]         pend_h_reg;
    logic [ID_W-1:0]          pend_view_reg;
    logic [ID_W-1:0]          pend_epoch_reg;

    // Handshake: the input item moves on when the result register is empty or being read
    logic advance;
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Plan logic
    logic                 is_begin, is_commit, is_cancel;
    logic                 frame_match;
    logic                 begin_reject;
    logic [MASK_W-1:0]    mask;
    logic                 reset_hist;
    logic                 hv;
    logic [PHASE_W-1:0]   ph;
    logic                 begin_ok;
    logic                 commit_ok, cancel_ok;
    logic [3:0]           pend_phase_inc;
    logic [PHASE_W-1:0]   commit_next_phase;
    result_t              result_next;

    always_comb begin
        is_begin  = 1'b0;
        is_commit = 1'b0;
        is_cancel = 1'b0;
        unique case (in_req_reg)
            REQ_BEGIN:  is_begin  = 1'b1;
            REQ_COMMIT: is_commit = 1'b1;
            REQ_CANCEL: is_cancel = 1'b1;
            default: ;
        endcase

        frame_match = pend_reg && (pend_frame_reg == in_frame_reg);
        commit_ok   = is_commit && frame_match;
        cancel_ok   = is_cancel && frame_match;

        begin_reject = pend_reg || (in_frame_reg == '0) || (in_w_reg == '0) ||
                       (in_h_reg == '0) ||
                       ((last_commit_reg != '0) && (in_frame_reg <= last_commit_reg));

        // reset reasons
        mask = '0;
        if (!in_en_reg) begin
            mask[RST_DISABLED] = active_reg;
            reset_hist = active_reg;
        end else begin
            if (!active_reg) begin
                mask[RST_ACTIVATED] = 1'b1;
            end else begin
                mask[RST_EXTENT]   = (com_w_reg != in_w_reg) || (com_h_reg != in_h_reg);
                mask[RST_VIEW]     = (com_view_reg != in_view_reg);
                mask[RST_TOPOLOGY] = (com_epoch_reg != in_epoch_reg);
                mask[RST_GAP]      = (last_commit_reg != '0) &&
                                     (in_frame_reg != last_commit_reg + 32'd1);
            end
            mask[RST_CUT] = in_cut_reg;
            reset_hist = (mask != '0);
        end

        hv = in_en_reg && history_ok_reg && !reset_hist;
        ph = (in_en_reg && !reset_hist) ? next_phase_reg : '0;

        begin_ok = is_begin && !begin_reject &&
                   !((mask != '0) && (gen_count_reg == '1));

        // phase after commit: (phase + 1) wrapped, low bits kept
        pend_phase_inc = {1'b0, pend_phase_reg} + 4'd1;
        if ({5'd0, pend_phase_inc} == PH_WRAP) begin
            commit_next_phase = '0;
        end else begin
            commit_next_phase = pend_phase_inc[PHASE_W-1:0];
        end

        // result item, zero unless accepted
        result_next = '0;
        if (commit_ok || cancel_ok) begin
            result_next.accepted = 1'b1;
        end else if (begin_ok) begin
            result_next.accepted            = 1'b1;
            result_next.plan_enabled        = in_en_reg;
            result_next.reset_mask          = mask;
            result_next.generation          = gen_count_reg + {31'd0, reset_hist};
            result_next.history_valid       = hv;
            result_next.history_read_index  = hv & last_wbuf_reg;
            result_next.history_write_index = hv & ~last_wbuf_reg;
            result_next.jitter_phase        = ph;
            if (in_en_reg) begin
                result_next.jitter_x = halton2_q16(ph);
                result_next.jitter_y = halton3_q16(ph);
            end
            if (hv) begin
                result_next.prev_jitter_x = saved_jx_reg;
                result_next.prev_jitter_y = saved_jy_reg;
            end
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_req_reg   <= s_req_type;
            in_frame_reg <= s_frame_id;
            in_en_reg    <= s_enabled;
            in_cut_reg   <= s_camera_cut;
            in_w_reg     <= s_width;
            in_h_reg     <= s_height;
            in_view_reg  <= s_view_id;
            in_epoch_reg <= s_topology_epoch;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

    // Committed state and pending plan, updated as an item is decided
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            history_ok_reg  <= 1'b0;
            last_wbuf_reg   <= 1'b0;
            next_phase_reg  <= '0;
            saved_jx_reg    <= '0;
            saved_jy_reg    <= '0;
            gen_count_reg   <= '0;
            last_commit_reg <= '0;
            com_w_reg       <= '0;
            com_h_reg       <= '0;
            com_view_reg    <= '0;
            com_epoch_reg   <= '0;
            pend_reg        <= 1'b0;
        end else if (advance) begin
            if (commit_ok) begin
                gen_count_reg   <= pend_gen_reg;
                last_commit_reg <= in_frame_reg;
                com_w_reg       <= pend_w_reg;
                com_h_reg       <= pend_h_reg;
                com_view_reg    <= pend_view_reg;
                com_epoch_reg   <= pend_epoch_reg;
                active_reg      <= pend_en_reg;
                history_ok_reg  <= pend_en_reg;
                if (pend_en_reg) begin
                    last_wbuf_reg  <= pend_wbuf_reg;
                    next_phase_reg <= commit_next_phase;
                    saved_jx_reg   <= pend_jx_reg;
                    saved_jy_reg   <= pend_jy_reg;
                end else begin
                    last_wbuf_reg  <= 1'b0;
                    next_phase_reg <= '0;
                    saved_jx_reg   <= '0;
                    saved_jy_reg   <= '0;
                end
            end
            if (commit_ok || cancel_ok) begin
                pend_reg <= 1'b0;
            end else if (begin_ok) begin
                pend_reg <= 1'b1;
            end
        end
    end

    // Pending plan payload; only read while a plan is pending
    always_ff @(posedge aclk) begin
        if (advance && begin_ok) begin
            pend_frame_reg <= in_frame_reg;
            pend_en_reg    <= in_en_reg;
            pend_gen_reg   <= result_next.generation;
            pend_wbuf_reg  <= result_next.history_write_index;
            pend_phase_reg <= ph;
            pend_jx_reg    <= result_next.jitter_x;
            pend_jy_reg    <= result_next.jitter_y;
            pend_w_reg     <= in_w_reg;
            pend_h_reg     <= in_h_reg;
            pend_view_reg  <= in_view_reg;
            pend_epoch_reg <= in_epoch_reg;
        end
    end

    // Output ports
    assign m_valid               = out_valid_reg;
    assign m_accepted            = out_reg.accepted;
    assign m_plan_enabled        = out_reg.plan_enabled;
    assign m_reset_mask          = out_reg.reset_mask;
    assign m_generation          = out_reg.generation;
    assign m_history_valid       = out_reg.history_valid;
    assign m_history_read_index  = out_reg.history_read_index;
    assign m_history_write_index = out_reg.history_write_index;
    assign m_jitter_phase        = out_reg.jitter_phase;
    assign m_jitter_x            = out_reg.jitter_x;
    assign m_jitter_y            = out_reg.jitter_y;
    assign m_prev_jitter_x       = out_reg.prev_jitter_x;
    assign m_prev_jitter_y       = out_reg.prev_jitter_y;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for temporal_history_frame_sequencer_unit. Requests go
// in over a valid/ready channel. A request-level predictor of the frame state
// (committed frame, pending plan, ping-pong buffers, Halton jitter) works out
// the result of each request taken in. A checker compares every returned
// result, field by field, with the oldest prediction. Directed requests come
// first, then random begin/commit/cancel frames with noise. Traffic runs
// under several idle and stall mixes, a long receiver hold-off and a full
// drain pause, and ends with the largest frame number.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import thfs_pkg::*;

    localparam int PHASES       = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int TAIL_CYCLES  = 8;
    localparam int REPORT_LIMIT = 10;
    // request code with no meaning in the block
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // request channel
    logic                    s_valid          = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_req_type       = '0;
    logic [ID_W-1:0]         s_frame_id       = '0;
    logic                    s_enabled        = 1'b0;
    logic                    s_camera_cut     = 1'b0;
    logic [EXT_W-1:0]        s_width          = '0;
    logic [EXT_W-1:0]        s_height         = '0;
    logic [ID_W-1:0]         s_view_id        = '0;
    logic [ID_W-1:0]         s_topology_epoch = '0;

    // result channel
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_accepted;
    logic                    m_plan_enabled;
    logic [MASK_W-1:0]       m_reset_mask;
    logic [ID_W-1:0]         m_generation;
    logic                    m_history_valid;
    logic                    m_history_read_index;
    logic                    m_history_write_index;
    logic [PHASE_W-1:0]      m_jitter_phase;
    logic signed [JIT_W-1:0] m_jitter_x;
    logic signed [JIT_W-1:0] m_jitter_y;
    logic signed [JIT_W-1:0] m_prev_jitter_x;
    logic signed [JIT_W-1:0] m_prev_jitter_y;

    // traffic shaping
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_on        = 1'b0;
    int          hold_cnt       = 0;

    int          fault_count    = 0;
    int          cycle_count    = 0;
    int unsigned items_sent     = 0;

    result_t     planned_results[$];

    // committed frame state
    logic               run_on     = 1'b0;
    logic               hist_ok    = 1'b0;
    logic               last_wbuf  = 1'b0;
    logic [PHASE_W-1:0] phase_nxt  = '0;
    logic [JIT_W-1:0]   saved_jx   = '0;
    logic [JIT_W-1:0]   saved_jy   = '0;
    logic [ID_W-1:0]    gen_cnt    = '0;
    logic [ID_W-1:0]    last_frame = '0;
    logic [EXT_W-1:0]   live_w     = '0;
    logic [EXT_W-1:0]   live_h     = '0;
    logic [ID_W-1:0]    live_view  = '0;
    logic [ID_W-1:0]    live_epoch = '0;

    // plan waiting for commit or cancel
    logic               plan_open  = 1'b0;
    logic [ID_W-1:0]    plan_frame = '0;
    logic               plan_en    = 1'b0;
    logic [ID_W-1:0]    plan_gen   = '0;
    logic               plan_wbuf  = 1'b0;
    logic [PHASE_W-1:0] plan_phase = '0;
    logic [JIT_W-1:0]   plan_jx    = '0;
    logic [JIT_W-1:0]   plan_jy    = '0;
    logic [EXT_W-1:0]   plan_w     = '0;
    logic [EXT_W-1:0]   plan_h     = '0;
    logic [ID_W-1:0]    plan_view  = '0;
    logic [ID_W-1:0]    plan_epoch = '0;

    temporal_history_frame_sequencer_unit #(
        .JITTER_PHASES(PHASES)
    ) uut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_req_type            (s_req_type),
        .s_frame_id            (s_frame_id),
        .s_enabled             (s_enabled),
        .s_camera_cut          (s_camera_cut),
        .s_width               (s_width),
        .s_height              (s_height),
        .s_view_id             (s_view_id),
        .s_topology_epoch      (s_topology_epoch),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_accepted            (m_accepted),
        .m_plan_enabled        (m_plan_enabled),
        .m_reset_mask          (m_reset_mask),
        .m_generation          (m_generation),
        .m_history_valid       (m_history_valid),
        .m_history_read_index  (m_history_read_index),
        .m_history_write_index (m_history_write_index),
        .m_jitter_phase        (m_jitter_phase),
        .m_jitter_x            (m_jitter_x),
        .m_jitter_y            (m_jitter_y),
        .m_prev_jitter_x       (m_prev_jitter_x),
        .m_prev_jitter_y       (m_prev_jitter_y)
    );

    // Radical inverse of idx in the given base, Q0.16 rounded, less one half
    function automatic logic [JIT_W-1:0] radical_q16(int unsigned idx, int unsigned base);
        longint unsigned num;
        longint unsigned den;
        longint unsigned scaled;
        num = 0;
        den = 1;
        while (idx != 0) begin
            num = num * base + idx % base;
            den = den * base;
            idx = idx / base;
        end
        scaled = (num * 64'd131072 + den) / (64'd2 * den);
        return JIT_W'(scaled - 64'd32768);
    endfunction

    // Frame planner: result of one request, and the state change it makes
    function automatic result_t plan_request(logic [1:0] rq, logic [ID_W-1:0] fid, logic en,
                                             logic cut, logic [EXT_W-1:0] w,
                                             logic [EXT_W-1:0] h, logic [ID_W-1:0] view,
                                             logic [ID_W-1:0] epoch);
        result_t            r;
        logic [MASK_W-1:0]  mask;
        logic               reset_hist;
        logic               hv;
        logic               rd;
        logic               wr;
        logic [ID_W-1:0]    gen;
        logic [PHASE_W-1:0] ph;
        logic [JIT_W-1:0]   jx;
        logic [JIT_W-1:0]   jy;
        logic [JIT_W-1:0]   pjx;
        logic [JIT_W-1:0]   pjy;
        r          = '0;
        mask       = '0;
        reset_hist = 1'b0;
        hv         = 1'b0;
        rd         = 1'b0;
        wr         = 1'b0;
        ph         = '0;
        jx         = '0;
        jy         = '0;
        pjx        = '0;
        pjy        = '0;

        // commit / cancel must name the pending frame
        if (rq == REQ_COMMIT || rq == REQ_CANCEL) begin
            if (plan_open && plan_frame == fid) begin
                if (rq == REQ_COMMIT) begin
                    gen_cnt    = plan_gen;
                    last_frame = fid;
                    live_w     = plan_w;
                    live_h     = plan_h;
                    live_view  = plan_view;
                    live_epoch = plan_epoch;
                    run_on     = plan_en;
                    if (plan_en) begin
                        hist_ok   = 1'b1;
                        last_wbuf = plan_wbuf;
                        phase_nxt = PHASE_W'((plan_phase + 1) % PHASES);
                        saved_jx  = plan_jx;
                        saved_jy  = plan_jy;
                    end else begin
                        hist_ok   = 1'b0;
                        last_wbuf = 1'b0;
                        phase_nxt = '0;
                        saved_jx  = '0;
                        saved_jy  = '0;
                    end
                end
                plan_open  = 1'b0;
                plan_frame = '0;
                plan_en    = 1'b0;
                plan_gen   = '0;
                plan_wbuf  = 1'b0;
                plan_phase = '0;
                plan_jx    = '0;
                plan_jy    = '0;
                plan_w     = '0;
                plan_h     = '0;
                plan_view  = '0;
                plan_epoch = '0;
                r.accepted = 1'b1;
            end
            return r;
        end
        if (rq != REQ_BEGIN)
            return r;

        // begin refusals
        if (plan_open || fid == 0 || w == 0 || h == 0 || (last_frame != 0 && fid <= last_frame))
            return r;

        if (!en) begin
            if (run_on)
                mask[RST_DISABLED] = 1'b1;
            gen = gen_cnt + ((mask != 0) ? 32'd1 : 32'd0);
        end else begin
            if (!run_on) begin
                mask[RST_ACTIVATED] = 1'b1;
                reset_hist          = 1'b1;
            end else begin
                if (live_w != w || live_h != h)
                    mask[RST_EXTENT] = 1'b1;
                if (live_view != view)
                    mask[RST_VIEW] = 1'b1;
                if (live_epoch != epoch)
                    mask[RST_TOPOLOGY] = 1'b1;
                if (last_frame != 0 && fid != last_frame + 32'd1)
                    mask[RST_GAP] = 1'b1;
                reset_hist = (mask != 0);
            end
            if (cut) begin
                mask[RST_CUT] = 1'b1;
                reset_hist    = 1'b1;
            end
            gen = gen_cnt + (reset_hist ? 32'd1 : 32'd0);
            hv  = hist_ok && !reset_hist;
            rd  = hv ? last_wbuf : 1'b0;
            wr  = hv ? !last_wbuf : 1'b0;
            ph  = reset_hist ? '0 : phase_nxt;
            jx  = radical_q16(ph % PHASES + 1, 2);
            jy  = radical_q16(ph % PHASES + 1, 3);
            if (hv) begin
                pjx = saved_jx;
                pjy = saved_jy;
            end
        end
        // generation ceiling: takes 2^32 - 1 resets, out of reach of a run
        if (mask != 0 && gen_cnt == '1)
            return r;

        plan_open  = 1'b1;
        plan_frame = fid;
        plan_en    = en;
        plan_gen   = gen;
        plan_wbuf  = wr;
        plan_phase = ph;
        plan_jx    = jx;
        plan_jy    = jy;
        plan_w     = w;
        plan_h     = h;
        plan_view  = view;
        plan_epoch = epoch;

        r.accepted            = 1'b1;
        r.plan_enabled        = en;
        r.reset_mask          = mask;
        r.generation          = gen;
        r.history_valid       = hv;
        r.history_read_index  = rd;
        r.history_write_index = wr;
        r.jitter_phase        = ph;
        r.jitter_x            = jx;
        r.jitter_y            = jy;
        r.prev_jitter_x       = pjx;
        r.prev_jitter_y       = pjy;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            if (fault_count < REPORT_LIMIT)
                $display("%0t mismatch %s: expected %h got %h", $realtime, name, want, got);
            fault_count++;
        end
    endfunction

    // Result checker, sampled at the rising edge
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (planned_results.size() == 0) begin
                if (fault_count < REPORT_LIMIT)
                    $display("%0t result item with nothing expected", $realtime);
                fault_count++;
            end else begin
                want = planned_results.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(m_accepted));
                check_field("plan_enabled", 32'(want.plan_enabled), 32'(m_plan_enabled));
                check_field("reset_mask", 32'(want.reset_mask), 32'(m_reset_mask));
                check_field("generation", want.generation, m_generation);
                check_field("history_valid", 32'(want.history_valid),
                            32'(m_history_valid));
                check_field("history_read_index", 32'(want.history_read_index),
                            32'(m_history_read_index));
                check_field("history_write_index", 32'(want.history_write_index),
                            32'(m_history_write_index));
                check_field("jitter_phase", 32'(want.jitter_phase), 32'(m_jitter_phase));
                check_field("jitter_x", 32'(want.jitter_x), 32'(m_jitter_x));
                check_field("jitter_y", 32'(want.jitter_y), 32'(m_jitter_y));
                check_field("prev_jitter_x", 32'(want.prev_jitter_x),
                            32'(m_prev_jitter_x));
                check_field("prev_jitter_y", 32'(want.prev_jitter_y),
                            32'(m_prev_jitter_y));
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off while hold_on is up
    always @(negedge aclk) begin
        if (hold_on && hold_cnt < HOLD_CYCLES) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            if (!hold_on)
                hold_cnt <= 0;
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one item from a falling edge, wait for the handshake, predict
    task automatic send_item(input logic [1:0] rq, input logic [ID_W-1:0] fid, input logic en,
                             input logic cut, input logic [EXT_W-1:0] w,
                             input logic [EXT_W-1:0] h, input logic [ID_W-1:0] view,
                             input logic [ID_W-1:0] epoch);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(negedge aclk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        s_req_type       <= rq;
        s_frame_id       <= fid;
        s_enabled        <= en;
        s_camera_cut     <= cut;
        s_width          <= w;
        s_height         <= h;
        s_view_id        <= view;
        s_topology_epoch <= epoch;
        s_valid          <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        planned_results.push_back(plan_request(rq, fid, en, cut, w, h, view, epoch));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_with_junk(input logic [1:0] rq, input logic [ID_W-1:0] fid);
        send_item(rq, fid, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  EXT_W'($urandom_range(16384)), EXT_W'($urandom_range(16384)),
                  $urandom, $urandom);
    endtask

    function automatic logic [EXT_W-1:0] pick_extent();
        case ($urandom_range(9))
            0:       return EXT_W'(1);
            1:       return EXT_W'(16384);
            default: return EXT_W'($urandom_range(16384, 1));
        endcase
    endfunction

    // Stray or broken requests
    task automatic send_noise();
        logic [ID_W-1:0]  fid;
        logic [EXT_W-1:0] w;
        logic [EXT_W-1:0] h;
        case ($urandom_range(4))
            0: send_with_junk(($urandom_range(1) != 0) ? REQ_COMMIT : REQ_CANCEL, $urandom);
            1: send_with_junk(REQ_UNKNOWN, $urandom);
            2: begin
                // zero extent on one or both axes
                w = ($urandom_range(1) != 0) ? '0 : pick_extent();
                h = (w == 0 && $urandom_range(1) != 0) ? pick_extent() : '0;
                send_item(REQ_BEGIN, last_frame + 32'd1, 1'($urandom_range(1)),
                          1'($urandom_range(1)), w, h, $urandom, $urandom);
            end
            3: send_with_junk(REQ_BEGIN, $urandom_range(last_frame));
            default: begin
                fid = $urandom;
                send_with_junk(REQ_BEGIN, fid);
                send_with_junk(REQ_CANCEL, fid);
            end
        endcase
    endtask

    // Mostly well-formed frames: begin, maybe noise, then commit or cancel
    task automatic run_random_traffic(input int unsigned n_items);
        int unsigned      stop_at;
        logic [ID_W-1:0]  fid;
        logic [EXT_W-1:0] w;
        logic [EXT_W-1:0] h;
        logic [ID_W-1:0]  view;
        logic [ID_W-1:0]  epoch;
        logic             en;
        logic             cut;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 80) begin
                fid = last_frame + (($urandom_range(99) < 88) ? 1 : $urandom_range(5, 2));
                if ($urandom_range(99) < 85 && live_w != 0) begin
                    w = live_w;
                    h = live_h;
                end else begin
                    w = pick_extent();
                    h = pick_extent();
                end
                view  = ($urandom_range(99) < 85) ? live_view : $urandom;
                epoch = ($urandom_range(99) < 85) ? live_epoch : $urandom;
                en    = ($urandom_range(99) < 85);
                cut   = ($urandom_range(99) < 8);
                send_item(REQ_BEGIN, fid, en, cut, w, h, view, epoch);
                if ($urandom_range(99) < 12)
                    send_noise();
                send_with_junk(($urandom_range(99) < 75) ? REQ_COMMIT : REQ_CANCEL, fid);
            end else begin
                send_noise();
            end
        end
    endtask

    // Drop valid and wait out every outstanding result
    task automatic settle();
        s_valid <= 1'b0;
        while (planned_results.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    // Requests refused straight after reset
    task automatic test_idle_requests();
        send_item(REQ_COMMIT, '0, 1'b0, 1'b0, '0, '0, '0, '0);
        send_item(REQ_CANCEL, '0, 1'b0, 1'b0, '0, '0, '0, '0);
        send_item(REQ_UNKNOWN, '1, 1'b1, 1'b1, EXT_W'(16384), EXT_W'(16384), '1, '1);
        send_item(REQ_BEGIN, '0, 1'b1, 1'b0, EXT_W'(64), EXT_W'(64), '0, '0);
        send_item(REQ_BEGIN, 32'd1, 1'b1, 1'b0, '0, EXT_W'(64), '0, '0);
        send_item(REQ_BEGIN, 32'd1, 1'b1, 1'b0, EXT_W'(64), '0, '0, '0);
    endtask

    // Frame lifecycle through each reset reason
    task automatic test_history_walk();
        // disabled frame while inactive: no reset
        send_item(REQ_BEGIN, 32'd1, 1'b0, 1'b0, EXT_W'(64), EXT_W'(64), '0, '0);
        send_item(REQ_COMMIT, 32'd1, 1'b0, 1'b0, '0, '0, '0, '0);
        // activation at the largest extent the bench uses
        send_item(REQ_BEGIN, 32'd2, 1'b1, 1'b0, EXT_W'(16384), EXT_W'(16384), '1, '1);
        // second begin while pending, commit naming the wrong frame
        send_item(REQ_BEGIN, 32'd3, 1'b1, 1'b0, EXT_W'(16384), EXT_W'(16384), '1, '1);
        send_item(REQ_COMMIT, 32'd3, 1'b0, 1'b0, '0, '0, '0, '0);
        send_item(REQ_COMMIT, 32'd2, 1'b0, 1'b0, '0, '0, '0, '0);
        // steady frame: history valid, buffers swap
        send_item(REQ_BEGIN, 32'd3, 1'b1, 1'b0, EXT_W'(16384), EXT_W'(16384), '1, '1);
        send_item(REQ_COMMIT, 32'd3, 1'b0, 1'b0, '0, '0, '0, '0);
        // every change plus a camera cut at the top frame number, then dropped
        send_item(REQ_BEGIN, '1, 1'b1, 1'b1, EXT_W'(640), EXT_W'(480), 32'h1234_5678, 32'd7);
        send_item(REQ_CANCEL, '1, 1'b0, 1'b0, '0, '0, '0, '0);
        // smallest extent, new view and epoch, no gap
        send_item(REQ_BEGIN, 32'd4, 1'b1, 1'b0, EXT_W'(1), EXT_W'(1), '0, '0);
        send_item(REQ_COMMIT, 32'd4, 1'b0, 1'b0, '0, '0, '0, '0);
        // disable while active
        send_item(REQ_BEGIN, 32'd5, 1'b0, 1'b0, EXT_W'(1), EXT_W'(1), '0, '0);
        send_item(REQ_COMMIT, 32'd5, 1'b0, 1'b0, '0, '0, '0, '0);
        // frame not newer than the committed one
        send_item(REQ_BEGIN, 32'd5, 1'b1, 1'b0, EXT_W'(1), EXT_W'(1), '0, '0);
    endtask

    task automatic test_random_traffic();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_traffic(225);
        send_idle_pct  = 84;
        recv_stall_pct = 0;
        run_random_traffic(225);
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        run_random_traffic(225);
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        run_random_traffic(225);
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_on        = 1'b1;
        run_random_traffic(16);
        hold_on        = 1'b0;
    endtask

    // Sender pauses until everything has come back
    task automatic test_drain_pause();
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        run_random_traffic(20);
        settle();
        run_random_traffic(20);
    endtask

    // Commit the top frame number; nothing newer exists after it
    task automatic test_frame_ceiling();
        logic [EXT_W-1:0] w;
        logic [EXT_W-1:0] h;
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        w = (live_w != 0) ? live_w : EXT_W'(1);
        h = (live_h != 0) ? live_h : EXT_W'(1);
        send_item(REQ_BEGIN, '1, 1'b1, 1'b0, w, h, live_view, live_epoch);
        send_item(REQ_COMMIT, '1, 1'b0, 1'b0, '0, '0, '0, '0);
        send_item(REQ_BEGIN, '1, 1'b1, 1'b0, w, h, live_view, live_epoch);
        send_item(REQ_CANCEL, '1, 1'b0, 1'b0, '0, '0, '0, '0);
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_idle_requests();
        test_history_walk();
        test_random_traffic();
        test_backpressure();
        test_drain_pause();
        test_frame_ceiling();
        settle();
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
hdl/thfs_pkg.sv
hdl/temporal_history_frame_sequencer_unit.sv
bench/tb.sv
